[sv/rgbprb_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers for the rgb16 image format probe
package rgbprb_pkg;

  localparam int MAX_BYTES    = 1048576;
  localparam int CNT_W        = $clog2(MAX_BYTES + 1);
  localparam int SCORE_WINDOW = 1000;
  localparam int SW_W         = $clog2(SCORE_WINDOW);

  localparam int HDR_W        = 16;
  localparam int WIDTH_W      = 10;
  localparam int HEIGHT_W     = 9;
  localparam int MAX_W        = 640;
  localparam int MAX_H        = 480;
  localparam int AREA_W       = WIDTH_W + HEIGHT_W;
  localparam int CMP_W        = (CNT_W > AREA_W) ? CNT_W : AREA_W;
  localparam int MIN_WORDS    = 16;

  localparam int NUM_GUESS    = 7;
  localparam int SPAN_W       = 10;
  localparam int QUOT_W       = 9;
  localparam int QUOT_SAT     = MAX_H + 1;
  localparam logic [WIDTH_W-1:0] GUESS_WIDTH [NUM_GUESS] =
    '{10'd320, 10'd256, 10'd240, 10'd160, 10'd128, 10'd80, 10'd64};

  localparam int FALLBACK_W     = 320;
  localparam int FALLBACK_H     = 240;
  localparam int FALLBACK_BYTES = FALLBACK_W * FALLBACK_H * 2;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGBA8888 = 2'd1,
    FMT_RGB555   = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [CNT_W-1:0]                   size;
    logic [HDR_W-1:0]                   hdr_w;
    logic [HDR_W-1:0]                   hdr_h;
    logic [SW_W-1:0]                    smooth_hdr;
    logic [SW_W-1:0]                    smooth_start;
    logic [NUM_GUESS-1:0]               hit;
    logic [NUM_GUESS-1:0][QUOT_W-1:0]   quot;
  } snap_t;

  function automatic logic [4:0] absd5(logic [4:0] a, logic [4:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [5:0] absd6(logic [5:0] a, logic [5:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic is_smooth(logic [15:0] cur, logic [15:0] prev);
    return (absd5(cur[15:11], prev[15:11]) < 5'd4) &&
           (absd6(cur[10:5], prev[10:5]) < 6'd6) &&
           (absd5(cur[4:0], prev[4:0]) < 5'd4);
  endfunction

  function automatic logic [SW_W-1:0] win_den(logic [CNT_W-2:0] n);
    logic [SW_W-1:0] d;
    if (n < SCORE_WINDOW) d = n[SW_W-1:0] - 1'b1;
    else d = SW_W'(SCORE_WINDOW - 1);
    return d;
  endfunction

endpackage

[sv/rgb16_image_format_probe_core.sv]
`timescale 1ns / 1ps
// top level of the rgb16 image format probe
//
//  channel | signals                               | beat
//  --------+---------------------------------------+----------------------------
//  in      | in_valid in_stall data_byte last       | one file byte
//  out     | out_valid out_stall detected width     | one decision per file,
//          | height format                          | after the byte with last
//
// one byte a cycle while in_stall is low; every byte updates the counters as it is accepted
// a decision leaves through the snapshot register, then the result register
// bytes keep flowing while a result waits; input stalls only when both the
// snapshot and the result register are full and out_stall is high
// rst is synchronous and clears all counters and valid flags
module rgb16_image_format_probe_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            detected,
  output logic [rgbprb_pkg::WIDTH_W-1:0]  width,
  output logic [rgbprb_pkg::HEIGHT_W-1:0] height,
  output logic [1:0]                      format
);
  import rgbprb_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  rgbprb_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last       (last),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  rgbprb_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .detected   (detected),
    .width      (width),
    .height     (height),
    .format     (format)
  );

endmodule

[sv/rgbprb_span.sv]
`timescale 1ns / 1ps
// running remainder and height count of the byte total for one candidate width
module rgbprb_span (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rgbprb_pkg::SPAN_W-1:0] span,
  input  logic                          step,
  input  logic                          clear,
  output logic                          hit,
  output logic [rgbprb_pkg::QUOT_W-1:0] quot
);
  import rgbprb_pkg::*;

  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] rem_next;
  logic [SPAN_W-1:0] rem_inc;
  logic [QUOT_W-1:0] rows;
  logic [QUOT_W-1:0] rows_next;
  logic              wrap;

  assign rem_inc = rem + 1'b1;
  assign wrap    = (rem_inc == span);

  always_comb begin
    rem_next  = rem;
    rows_next = rows;
    if (step) begin
      rem_next = wrap ? '0 : rem_inc;
      if (wrap && (rows != QUOT_W'(QUOT_SAT))) rows_next = rows + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rem  <= '0;
      rows <= '0;
    end else begin
      rem  <= rem_next;
      rows <= rows_next;
    end
  end

  // counts as they stand after the current beat
  assign hit  = (rem_next == '0) && (rows_next != '0) && (rows_next <= QUOT_W'(MAX_H));
  assign quot = rows_next;

endmodule

[sv/rgbprb_accum.sv]
`timescale 1ns / 1ps
// per-byte header capture, smoothness counting and end-of-file snapshot
module rgbprb_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic               snap_ready,
  output logic               snap_valid,
  output rgbprb_pkg::snap_t  snap
);
  import rgbprb_pkg::*;

  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [7:0]        low_byte_hold;
  logic [7:0]        low_byte_hold_next;
  logic [15:0]       previous_word;
  logic [15:0]       previous_word_next;
  logic [HDR_W-1:0]  header_width;
  logic [HDR_W-1:0]  header_width_next;
  logic [HDR_W-1:0]  header_height;
  logic [HDR_W-1:0]  header_height_next;
  logic [SW_W-1:0]   smooth_after_header;
  logic [SW_W-1:0]   smooth_after_header_next;
  logic [SW_W-1:0]   smooth_from_start;
  logic [SW_W-1:0]   smooth_from_start_next;

  logic              accept;
  logic              step;
  logic              done;
  logic [15:0]       word;
  logic [CNT_W-2:0]  k;
  logic              sm;
  logic [NUM_GUESS-1:0]             hit;
  logic [NUM_GUESS-1:0][QUOT_W-1:0] quot;

  assign in_stall = snap_valid && !snap_ready;
  assign accept   = in_valid && !in_stall;
  assign step     = accept && (byte_count < CNT_W'(MAX_BYTES));
  assign done     = accept && last;
  assign word     = {data_byte, low_byte_hold};
  assign k        = byte_count[CNT_W-1:1];
  assign sm       = is_smooth(word, previous_word);

  always_comb begin
    byte_count_next          = byte_count;
    low_byte_hold_next       = low_byte_hold;
    previous_word_next       = previous_word;
    header_width_next        = header_width;
    header_height_next       = header_height;
    smooth_after_header_next = smooth_after_header;
    smooth_from_start_next   = smooth_from_start;
    if (step) begin
      byte_count_next = byte_count + 1'b1;
      case (byte_count)
        CNT_W'(0): header_width_next  = {8'h00, data_byte};
        CNT_W'(1): header_width_next  = {data_byte, header_width[7:0]};
        CNT_W'(2): header_height_next = {8'h00, data_byte};
        CNT_W'(3): header_height_next = {data_byte, header_height[7:0]};
        default: ;
      endcase
      if (!byte_count[0]) begin
        low_byte_hold_next = data_byte;
      end else begin
        previous_word_next = word;
        if ((k != '0) && sm) begin
          if (k < SCORE_WINDOW) smooth_from_start_next = smooth_from_start + 1'b1;
          // window that opens after the header words
          if ((k >= 3) && (k < SCORE_WINDOW + 2)) begin
            smooth_after_header_next = smooth_after_header + 1'b1;
          end
        end
      end
    end
  end

  for (genvar i = 0; i < NUM_GUESS; i++) begin : g_span
    rgbprb_span u_span (
      .clk   (clk),
      .rst   (rst),
      .span  ({GUESS_WIDTH[i][SPAN_W-2:0], 1'b0}),
      .step  (step),
      .clear (done),
      .hit   (hit[i]),
      .quot  (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      byte_count          <= '0;
      low_byte_hold       <= '0;
      previous_word       <= '0;
      header_width        <= '0;
      header_height       <= '0;
      smooth_after_header <= '0;
      smooth_from_start   <= '0;
    end else begin
      byte_count          <= byte_count_next;
      low_byte_hold       <= low_byte_hold_next;
      previous_word       <= previous_word_next;
      header_width        <= header_width_next;
      header_height       <= header_height_next;
      smooth_after_header <= smooth_after_header_next;
      smooth_from_start   <= smooth_from_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (done) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      snap.size         <= byte_count_next;
      snap.hdr_w        <= header_width_next;
      snap.hdr_h        <= header_height_next;
      snap.smooth_hdr   <= smooth_after_header_next;
      snap.smooth_start <= smooth_from_start_next;
      snap.hit          <= hit;
      snap.quot         <= quot;
    end
  end

endmodule

[sv/rgbprb_decide.sv]
`timescale 1ns / 1ps
// format decision from the end-of-file snapshot and the result register
module rgbprb_decide (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             snap_valid,
  input  rgbprb_pkg::snap_t                snap,
  output logic                             snap_ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             detected,
  output logic [rgbprb_pkg::WIDTH_W-1:0]   width,
  output logic [rgbprb_pkg::HEIGHT_W-1:0]  height,
  output logic [1:0]                       format
);
  import rgbprb_pkg::*;

  logic [CNT_W-1:0]    size_m4;
  logic [CNT_W-2:0]    n16;
  logic [CNT_W-3:0]    n32;
  logic [CNT_W-2:0]    n_all;
  logic [AREA_W-1:0]   area;
  logic                big_enough;
  logic                hdr_ok;
  logic                hdr_565;
  logic                hdr_8888;
  logic                guess_good;
  logic                any_hit;
  logic [2:0]          sel;
  logic [SW_W-1:0]     den_hdr;
  logic [SW_W-1:0]     den_start;

  logic                det_next;
  logic [WIDTH_W-1:0]  width_next;
  logic [HEIGHT_W-1:0] height_next;
  fmt_t                format_next;

  assign size_m4    = snap.size - CNT_W'(4);
  assign n16        = size_m4[CNT_W-1:1];
  assign n32        = size_m4[CNT_W-1:2];
  assign n_all      = snap.size[CNT_W-1:1];
  assign big_enough = (snap.size >= CNT_W'(4));
  assign hdr_ok     = (snap.hdr_w != '0) && (snap.hdr_w <= HDR_W'(MAX_W)) &&
                      (snap.hdr_h != '0) && (snap.hdr_h <= HDR_W'(MAX_H));
  assign area       = AREA_W'(snap.hdr_w[WIDTH_W-1:0]) * AREA_W'(snap.hdr_h[HEIGHT_W-1:0]);
  assign den_hdr    = win_den(n16);
  assign den_start  = win_den(n_all);

  assign hdr_565  = hdr_ok && (CMP_W'(n16) == CMP_W'(area)) && (n16 >= MIN_WORDS) &&
                    ({snap.smooth_hdr, 1'b0} > {1'b0, den_hdr});
  assign hdr_8888 = hdr_ok && (CMP_W'(n32) == CMP_W'(area));

  // score above 0.6 as 5 * smooth > 3 * span
  assign guess_good = (n_all >= MIN_WORDS) &&
                      ((SW_W + 3)'(snap.smooth_start) * 3'd5 >
                       (SW_W + 3)'(den_start) * 3'd3);

  assign any_hit = |snap.hit;

  always_comb begin
    sel = 3'd0;
    for (int i = NUM_GUESS - 1; i >= 0; i--) begin
      if (snap.hit[i]) sel = 3'(i);
    end
  end

  always_comb begin
    det_next    = 1'b0;
    width_next  = '0;
    height_next = '0;
    format_next = FMT_RGB565;
    if (big_enough) begin
      if (hdr_565 || hdr_8888) begin
        det_next    = 1'b1;
        width_next  = snap.hdr_w[WIDTH_W-1:0];
        height_next = snap.hdr_h[HEIGHT_W-1:0];
        format_next = hdr_565 ? FMT_RGB565 : FMT_RGBA8888;
      end else if (any_hit) begin
        det_next    = 1'b1;
        width_next  = GUESS_WIDTH[sel];
        height_next = snap.quot[sel];
        format_next = guess_good ? FMT_RGB565 : FMT_RGB555;
      end else if (32'(snap.size) >= FALLBACK_BYTES) begin
        det_next    = 1'b1;
        width_next  = WIDTH_W'(FALLBACK_W);
        height_next = HEIGHT_W'(FALLBACK_H);
        format_next = FMT_RGB565;
      end
    end
  end

  assign snap_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      detected <= det_next;
      width    <= width_next;
      height   <= height_next;
      format   <= format_next;
    end
  end

endmodule

[sv/rgbprb_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the rgb16 image format probe, bound to the top level
module rgbprb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            detected,
  input logic [rgbprb_pkg::WIDTH_W-1:0]  width,
  input logic [rgbprb_pkg::HEIGHT_W-1:0] height,
  input logic [1:0]                      format
);
  import rgbprb_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable(detected) && $stable(width) && $stable(height) && $stable(format))
    else $error("result beat changed while stalled");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !detected |-> width == '0 && height == '0 && format == FMT_RGB565)
    else $error("empty result with non-zero fields");

  a_found_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && detected |-> width != '0 && height != '0 &&
      width <= WIDTH_W'(MAX_W) && height <= HEIGHT_W'(MAX_H) &&
      (format == FMT_RGB565 || format == FMT_RGBA8888 || format == FMT_RGB555))
    else $error("detected result out of range");

endmodule

bind rgb16_image_format_probe_core rgbprb_checker u_rgbprb_checker (.*);

[verif/rgb16_image_format_probe_check.sv]
`timescale 1ns / 1ps
// checker for the rgb16 image format probe: watches both channels, predicts and compares decisions
module rgb16_image_format_probe_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            detected,
  input  logic [rgbprb_pkg::WIDTH_W-1:0]  width,
  input  logic [rgbprb_pkg::HEIGHT_W-1:0] height,
  input  logic [1:0]                      format,
  output int                              errors,
  output int                              pending
);
  import rgbprb_pkg::*;

  typedef struct packed {
    logic               det;
    logic [WIDTH_W-1:0] w;
    logic [HEIGHT_W-1:0] h;
    fmt_t               f;
  } decision_t;

  decision_t   due_q[$];
  int unsigned file_bytes;
  logic [7:0]  low_hold;
  logic [15:0] prior_word;
  logic [15:0] hdr_w;
  logic [15:0] hdr_h;
  int unsigned smooth_body;
  int unsigned smooth_all;
  int          fails;

  function automatic bit gentle_step(logic [15:0] a, logic [15:0] b);
    int dr, dg, db;
    dr = int'(a[15:11]) - int'(b[15:11]);
    dg = int'(a[10:5]) - int'(b[10:5]);
    db = int'(a[4:0]) - int'(b[4:0]);
    return (dr < 4 && dr > -4) && (dg < 6 && dg > -6) && (db < 4 && db > -4);
  endfunction

  function automatic int unsigned score_den(int unsigned n);
    return (n < SCORE_WINDOW) ? n - 1 : SCORE_WINDOW - 1;
  endfunction

  function automatic decision_t classify(int unsigned size);
    decision_t   d;
    int unsigned n16, n32, area, span, hh, n;
    bit          good;
    d = '0;
    if (size < 4) return d;
    if (hdr_w > 0 && hdr_w <= MAX_W && hdr_h > 0 && hdr_h <= MAX_H) begin
      n16 = (size - 4) / 2;
      n32 = (size - 4) / 4;
      area = int'(hdr_w) * int'(hdr_h);
      if (n16 == area && n16 >= MIN_WORDS && 2 * smooth_body > score_den(n16)) begin
        d.det = 1'b1; d.w = hdr_w[WIDTH_W-1:0]; d.h = hdr_h[HEIGHT_W-1:0]; d.f = FMT_RGB565;
        return d;
      end
      if (n32 == area) begin
        d.det = 1'b1; d.w = hdr_w[WIDTH_W-1:0]; d.h = hdr_h[HEIGHT_W-1:0]; d.f = FMT_RGBA8888;
        return d;
      end
    end
    for (int i = 0; i < NUM_GUESS; i++) begin
      span = 2 * int'(GUESS_WIDTH[i]);
      if (size % span == 0) begin
        hh = size / span;
        if (hh > 0 && hh <= MAX_H) begin
          n = size / 2;
          good = (n >= MIN_WORDS) && (5 * smooth_all > 3 * score_den(n));
          d.det = 1'b1; d.w = GUESS_WIDTH[i]; d.h = HEIGHT_W'(hh);
          d.f = good ? FMT_RGB565 : FMT_RGB555;
          return d;
        end
      end
    end
    if (size >= FALLBACK_BYTES) begin
      d.det = 1'b1; d.w = WIDTH_W'(FALLBACK_W); d.h = HEIGHT_W'(FALLBACK_H); d.f = FMT_RGB565;
    end
    return d;
  endfunction

  task automatic clear_file();
    file_bytes = 0; low_hold = '0; prior_word = '0;
    hdr_w = '0; hdr_h = '0; smooth_body = 0; smooth_all = 0;
  endtask

  task automatic absorb(logic [7:0] b, logic fin);
    int unsigned k;
    logic [15:0] word;
    bit          sm;
    if (file_bytes < MAX_BYTES) begin
      case (file_bytes)
        0: hdr_w[7:0] = b;
        1: hdr_w[15:8] = b;
        2: hdr_h[7:0] = b;
        3: hdr_h[15:8] = b;
        default: ;
      endcase
      if (file_bytes[0] == 1'b0) begin
        low_hold = b;
      end else begin
        word = {b, low_hold};
        k = file_bytes >> 1;
        if (k >= 1) begin
          sm = gentle_step(word, prior_word);
          if (k < SCORE_WINDOW && sm) smooth_all++;
          if (k >= 3 && k - 2 < SCORE_WINDOW && sm) smooth_body++;
        end
        prior_word = word;
      end
      file_bytes++;
    end
    if (fin) begin
      due_q.push_back(classify(file_bytes));
      clear_file();
    end
  endtask

  always @(posedge clk) begin
    decision_t due;
    if (rst) begin
      clear_file();
      due_q.delete();
      fails = 0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected decision det=%0d w=%0d h=%0d fmt=%0d",
                     $realtime, detected, width, height, format);
          fails++;
        end else begin
          due = due_q.pop_front();
          if (detected !== due.det || width !== due.w || height !== due.h ||
              format !== due.f) begin
            if (fails < 10)
              $display("%0t: decision mismatch: expected det=%0d w=%0d h=%0d fmt=%0d, got det=%0d w=%0d h=%0d fmt=%0d",
                       $realtime, due.det, due.w, due.h, due.f,
                       detected, width, height, format);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) absorb(data_byte, last);
      pending <= due_q.size();
      errors <= fails;
    end
  end

endmodule

[verif/rgb16_image_format_probe_core_test.sv]
`timescale 1ns / 1ps
// testbench top for the rgb16 image format probe: file stimulus, idling and verdict
module rgb16_image_format_probe_core_test;
  import rgbprb_pkg::*;

  typedef enum {
    SHAPE_HDR565,
    SHAPE_HDR8888,
    SHAPE_GUESS,
    SHAPE_BADHDR,
    SHAPE_NOISE
  } shape_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'd0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                detected;
  logic [WIDTH_W-1:0]  width;
  logic [HEIGHT_W-1:0] height;
  logic [1:0]          format;
  int                  errors;
  int                  pending;

  int unsigned send_gap_pct = 34;
  int unsigned hold_pct = 87;
  logic [7:0]  file_buf[$];
  logic [15:0] walk_word;

  rgb16_image_format_probe_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .detected(detected), .width(width), .height(height), .format(format)
  );

  rgb16_image_format_probe_check checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .detected(detected), .width(width), .height(height), .format(format),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < hold_pct);

  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic ship_file();
    for (int i = 0; i < file_buf.size(); i++) send_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
  endtask

  task automatic put_header(logic [15:0] w, logic [15:0] h);
    file_buf.push_back(w[7:0]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(h[7:0]);
    file_buf.push_back(h[15:8]);
  endtask

  task automatic put_noise(int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
  endtask

  // random walk of pixels, jump_pct of them replaced by arbitrary words
  task automatic put_walk(int words, int unsigned jump_pct);
    logic [4:0] r, bl;
    logic [5:0] g;
    walk_word = 16'($urandom);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < jump_pct) begin
        walk_word = 16'($urandom);
      end else begin
        r = walk_word[15:11] + 5'($urandom_range(0, 6)) - 5'd3;
        g = walk_word[10:5] + 6'($urandom_range(0, 10)) - 6'd5;
        bl = walk_word[4:0] + 5'($urandom_range(0, 6)) - 5'd3;
        walk_word = {r, g, bl};
      end
      file_buf.push_back(walk_word[7:0]);
      file_buf.push_back(walk_word[15:8]);
    end
  endtask

  task automatic random_file(output int nbytes);
    int     pick, w, h;
    shape_t shape;
    pick = $urandom_range(0, 9);
    shape = (pick < 3) ? SHAPE_HDR565 : (pick < 5) ? SHAPE_HDR8888 :
            (pick < 6) ? SHAPE_GUESS : (pick < 8) ? SHAPE_BADHDR : SHAPE_NOISE;
    case (shape)
      SHAPE_HDR565: begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        put_header(16'(w), 16'(h));
        put_walk(w * h, $urandom_range(0, 100));
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1)) put_noise($urandom_range(1, 3));
          else void'(file_buf.pop_back());
        end
      end
      SHAPE_HDR8888: begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 4);
        put_header(16'(w), 16'(h));
        put_noise(4 * w * h);
      end
      SHAPE_GUESS: begin
        put_walk(int'(GUESS_WIDTH[$urandom_range(NUM_GUESS - 2, NUM_GUESS - 1)]),
                 $urandom_range(0, 100));
      end
      SHAPE_BADHDR: begin
        case ($urandom_range(0, 3))
          0: put_header(16'd0, 16'($urandom));
          1: put_header(16'($urandom_range(MAX_W + 1, 16'hFFFF)), 16'd1);
          2: put_header(16'($urandom), 16'($urandom_range(MAX_H + 1, 16'hFFFF)));
          default: put_header(16'hFFFF, 16'hFFFF);
        endcase
        put_noise($urandom_range(0, 60));
      end
      default: put_noise($urandom_range(1, 40));
    endcase
    nbytes = file_buf.size();
    ship_file();
  endtask

  task automatic random_burst();
    int files, total, n;
    files = 0;
    total = 0;
    while (files < 5 || total < 150) begin
      random_file(n);
      files++;
      total += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // tiny files, up to header size
    file_buf.push_back(8'h00); ship_file();
    file_buf.push_back(8'hFF); file_buf.push_back(8'hFF); ship_file();
    put_noise(3); ship_file();
    put_header(16'd4, 16'd4); ship_file();
    // header led files
    put_header(16'd4, 16'd4); put_walk(16, 0); ship_file();
    put_header(16'd4, 16'd4); put_walk(16, 100); ship_file();
    put_header(16'd4, 16'd4); put_noise(64); ship_file();
    put_header(16'd3, 16'd5); put_walk(15, 0); ship_file();
    put_header(16'd641, 16'd1); put_noise(12); ship_file();
    put_header(16'd1, 16'd481); put_noise(12); ship_file();
    put_header(16'd0, 16'd0); put_noise(28); ship_file();
    // headerless, width guessed from size
    put_walk(64, 0); ship_file();
    put_walk(64, 100); ship_file();

    random_burst();
    send_gap_pct = 87;
    hold_pct = 34;
    random_burst();
    send_gap_pct = 0;
    hold_pct = 0;
    random_burst();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
